@@ sv/windowed_base_mismatch_scorer_defines.svh @@
// Assertion macros used by the scorer datapath module.
`ifndef WINDOWED_BASE_MISMATCH_SCORER_DEFINES_SVH
`define WINDOWED_BASE_MISMATCH_SCORER_DEFINES_SVH

// The expression must hold at every clock edge outside reset.
`define WBMS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define WBMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/wbms_pkg.sv @@
`default_nettype none

package wbms_pkg;

    localparam int WINDOW_MAX  = 256;
    localparam int HIST_AW     = $clog2(WINDOW_MAX);
    localparam int WIN_W       = $clog2(WINDOW_MAX + 1);

    localparam int BASE_W      = 8;
    localparam int LEN_W       = 16;
    localparam int WLEN_W      = 9;
    localparam int FRAC_W      = 16;
    localparam int SCORE_W     = 14;
    localparam int WORST_W     = 9;
    localparam int POS_W       = 16;

    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;
    localparam int M_PAD_W     = M_TDATA_W - (SCORE_W + WORST_W + POS_W);

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAC       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_UNKNOWN = 2'd2;

    localparam logic [WLEN_W-1:0] WINDOW_LEN_RESET = 9'd30;
    localparam logic [FRAC_W-1:0] MAX_FRAC_RESET   = 16'd16384;

    localparam int MIN_READ_LEN = 3;
    localparam int FRAC_ROUND   = 1 << (FRAC_W - 1);

    localparam int SCORE_SCALE  = 10000;
    localparam int DIVIDEND_W   = 22;
    localparam int DIV_STEPS    = DIVIDEND_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    typedef logic [2:0] base_code_t;

    localparam base_code_t CODE_NONE = 3'd0;
    localparam base_code_t CODE_A    = 3'd1;
    localparam base_code_t CODE_C    = 3'd2;
    localparam base_code_t CODE_G    = 3'd3;
    localparam base_code_t CODE_T    = 3'd4;
    localparam base_code_t CODE_GAP  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_SCALE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic read;
        logic update;
        logic scale;
        logic div_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic exhausted;
        logic done;
        logic hit;
        logic out_free;
    } sts_t;

    function automatic base_code_t base_code(input logic [BASE_W-1:0] ch);
        base_code_t code;
        unique case (ch)
            8'h41, 8'h61:               code = CODE_A;
            8'h43, 8'h63:               code = CODE_C;
            8'h47, 8'h67:               code = CODE_G;
            8'h54, 8'h74, 8'h55, 8'h75: code = CODE_T;
            8'h2A, 8'h2C, 8'h2D:        code = CODE_GAP;
            default:                    code = CODE_NONE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

@@ sv/wbms_ctrl.sv @@
`default_nettype none

module wbms_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  wbms_pkg::sts_t   sts,
    output wbms_pkg::cmd_t   cmd
);
    import wbms_pkg::*;

    state_t                 state_reg;
    state_t                 state_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = sts.exhausted ? ST_IDLE : ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = sts.done ? ST_SCALE : ST_IDLE;
            end
            ST_SCALE: begin
                state_next = sts.hit ? ST_DIVIDE : ST_EMIT;
            end
            ST_DIVIDE: begin
                if (div_cnt_reg == DIV_LAST) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        div_cnt_next = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_READ: begin
                cmd.read = 1'b1;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
            end
            ST_SCALE: begin
                cmd.scale = 1'b1;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg != DIV_LAST) begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                cmd.emit = sts.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/wbms_dpath.sv @@
`default_nettype none

`include "windowed_base_mismatch_scorer_defines.svh"

module wbms_dpath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [wbms_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tuser,
    input  logic                             cfg_wr,
    input  logic [wbms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wbms_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wbms_pkg::cmd_t                   cmd,
    output wbms_pkg::sts_t                   sts,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [wbms_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tuser
);
    import wbms_pkg::*;

    logic [WLEN_W-1:0]      window_len_reg;
    logic [FRAC_W-1:0]      max_frac_reg;
    logic                   ignore_reg;

    logic [BASE_W-1:0]      read_base_reg;
    logic [BASE_W-1:0]      ref_base_reg;
    logic                   first_reg;

    logic [WIN_W-1:0]       win_reg;
    logic [LEN_W-1:0]       expected_reg;
    logic [LEN_W-1:0]       seen_reg;
    logic [WIN_W-1:0]       count_reg;
    logic [WIN_W-1:0]       worst_reg;
    logic [POS_W-1:0]       pos_reg;
    logic                   hit_reg;

    logic                   hist_mem [WINDOW_MAX];
    logic                   hist_q_reg;

    logic [DIVIDEND_W-1:0]  dq_reg;
    logic [WIN_W-1:0]       rem_reg;

    logic                   out_valid_reg;
    logic [SCORE_W-1:0]     score_reg;
    logic                   flagged_reg;
    logic [WORST_W-1:0]     worst_count_reg;
    logic [POS_W-1:0]       worst_end_reg;

    logic [BASE_W-1:0]      in_read_base;
    logic [BASE_W-1:0]      in_ref_base;
    logic [LEN_W-1:0]       in_read_len;
    logic [WIN_W-1:0]       win_sat;
    logic [WIN_W-1:0]       win_eff;
    logic [FRAC_W+WIN_W:0]  thr_sum;
    logic [WIN_W-1:0]       thr;
    logic                   win_nz;
    base_code_t             read_code;
    base_code_t             ref_code;
    logic                   miss;
    logic                   drop_old;
    logic [WIN_W-1:0]       count_new;
    logic [LEN_W-1:0]       seen_n1;
    logic                   new_worst;
    logic [HIST_AW-1:0]     rd_addr;
    logic [HIST_AW-1:0]     wr_addr;
    logic [DIVIDEND_W-1:0]  scaled;
    logic [WIN_W:0]         rem_sh;
    logic                   div_ge;

    assign in_read_base = s_tdata[BASE_W-1:0];
    assign in_ref_base  = s_tdata[2*BASE_W-1:BASE_W];
    assign in_read_len  = s_tdata[2*BASE_W+LEN_W-1:2*BASE_W];

    always_comb begin
        priority if (window_len_reg == '0) begin
            win_sat = WIN_W'(1);
        end else if (32'(window_len_reg) > WINDOW_MAX) begin
            win_sat = WIN_W'(WINDOW_MAX);
        end else begin
            win_sat = WIN_W'(window_len_reg);
        end
        priority if (in_read_len < LEN_W'(MIN_READ_LEN)) begin
            win_eff = '0;
        end else if ((in_read_len - LEN_W'(2)) < LEN_W'(win_sat)) begin
            win_eff = WIN_W'(in_read_len - LEN_W'(2));
        end else begin
            win_eff = win_sat;
        end
    end

    assign thr_sum = (FRAC_W+WIN_W+1)'(max_frac_reg) * (FRAC_W+WIN_W+1)'(win_reg)
                   + (FRAC_W+WIN_W+1)'(FRAC_ROUND);
    assign thr     = thr_sum[FRAC_W+WIN_W-1:FRAC_W];

    assign win_nz    = (win_reg != '0);
    assign read_code = base_code(read_base_reg);
    assign ref_code  = base_code(ref_base_reg);
    assign miss      = ignore_reg ? ((read_code != CODE_NONE) && (read_code != ref_code))
                                  : (read_code != ref_code);

    assign drop_old  = win_nz && (seen_reg >= LEN_W'(win_reg)) && hist_q_reg;
    assign count_new = count_reg - WIN_W'(drop_old) + WIN_W'(miss);
    assign seen_n1   = seen_reg + LEN_W'(1);
    assign new_worst = win_nz && (seen_n1 >= LEN_W'(win_reg)) && (count_new >= worst_reg);

    assign rd_addr = seen_reg[HIST_AW-1:0] - win_reg[HIST_AW-1:0];
    assign wr_addr = seen_reg[HIST_AW-1:0];

    assign scaled = DIVIDEND_W'(DIVIDEND_W'(worst_reg) * DIVIDEND_W'(SCORE_SCALE));
    assign rem_sh = {rem_reg, dq_reg[DIVIDEND_W-1]};
    assign div_ge = (rem_sh >= {1'b0, win_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= WINDOW_LEN_RESET;
            max_frac_reg   <= MAX_FRAC_RESET;
            ignore_reg     <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                CFG_WINDOW_LEN:     window_len_reg <= cfg_data[WLEN_W-1:0];
                CFG_MAX_FRAC:       max_frac_reg   <= cfg_data[FRAC_W-1:0];
                CFG_IGNORE_UNKNOWN: ignore_reg     <= cfg_data[0];
                default:            ignore_reg     <= ignore_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            read_base_reg <= in_read_base;
            ref_base_reg  <= in_ref_base;
        end
        if (cmd.scale) begin
            dq_reg  <= scaled;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            dq_reg  <= {dq_reg[DIVIDEND_W-2:0], div_ge};
            rem_reg <= div_ge ? WIN_W'(rem_sh - {1'b0, win_reg}) : rem_sh[WIN_W-1:0];
        end
        if (cmd.emit) begin
            score_reg       <= hit_reg ? dq_reg[SCORE_W-1:0] : '0;
            flagged_reg     <= hit_reg;
            worst_count_reg <= hit_reg ? WORST_W'(worst_reg) : '0;
            worst_end_reg   <= hit_reg ? pos_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg    <= 1'b0;
            win_reg      <= '0;
            expected_reg <= '0;
            seen_reg     <= '0;
            count_reg    <= '0;
            worst_reg    <= '0;
            pos_reg      <= '0;
            hit_reg      <= 1'b0;
        end else begin
            if (cmd.accept) begin
                first_reg <= s_tuser;
                if (s_tuser) begin
                    win_reg      <= win_eff;
                    expected_reg <= in_read_len;
                    seen_reg     <= '0;
                    count_reg    <= '0;
                    pos_reg      <= '0;
                    hit_reg      <= 1'b0;
                end
            end
            if (cmd.read && first_reg) begin
                worst_reg <= thr;
            end
            if (cmd.update) begin
                seen_reg <= seen_n1;
                if (win_nz) begin
                    count_reg <= count_new;
                end
                if (new_worst) begin
                    worst_reg <= count_new;
                    pos_reg   <= seen_n1;
                    hit_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update && win_nz) begin
            hist_mem[wr_addr] <= miss;
        end
        if (cmd.read) begin
            hist_q_reg <= hist_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.exhausted = (seen_reg >= expected_reg);
    assign sts.done      = (seen_n1 == expected_reg);
    assign sts.hit       = hit_reg;
    assign sts.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, worst_end_reg, worst_count_reg, score_reg};
    assign m_tuser  = flagged_reg;

    `WBMS_ASSERT_ALWAYS(a_count_in_window, count_reg <= win_reg, "window count exceeds window")
    `WBMS_ASSERT_ALWAYS(a_hit_needs_window, !hit_reg || win_nz, "hit recorded with empty window")
    `WBMS_ASSERT_NEXT(a_emit_shows_result, cmd.emit, out_valid_reg, "emitted result not valid")

endmodule

`default_nettype wire

@@ sv/windowed_base_mismatch_scorer.sv @@
// Each base pair passes through acceptance, history memory read and window update.
// On a read's last base the result is scaled and, when a window reached the threshold,
// divided by the 22-step shift-subtract score divider before it is emitted.
// The next item is accepted while a finished result waits in the output register.
// aresetn is synchronous and active low; it restores the register defaults and clears
// all control state; the history memory needs no clearing pass.
`default_nettype none

module windowed_base_mismatch_scorer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // read_base[7:0], ref_base[15:8], read_len[31:16]
    input  logic [wbms_pkg::S_TDATA_W-1:0]   s_tdata,
    // first_base[0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // score[13:0], worst_count[22:14], worst_end[38:23], zero[39]
    output logic [wbms_pkg::M_TDATA_W-1:0]   m_tdata,
    // flagged[0]
    output logic                             m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wbms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wbms_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import wbms_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    wbms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wbms_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr    (cfg_wr),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

@@ test/windowed_base_mismatch_scorer_checker.sv @@
`timescale 1ns / 100ps

module windowed_base_mismatch_scorer_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [wbms_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [wbms_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            m_tuser,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [wbms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wbms_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              errors,
    output int                              pending
);
    import wbms_pkg::*;

    localparam int WORST_LO = SCORE_W;
    localparam int END_LO   = SCORE_W + WORST_W;
    localparam int PAD_LO   = SCORE_W + WORST_W + POS_W;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               flagged;
        logic [WORST_W-1:0] worst_count;
        logic [POS_W-1:0]   worst_end;
    } read_score_t;

    read_score_t score_queue[$];

    logic [WLEN_W-1:0]     win_setting;
    logic [FRAC_W-1:0]     frac_setting;
    logic                  ignore_setting;

    logic [WINDOW_MAX-1:0] miss_hist;
    logic [WIN_W-1:0]      win_count;
    logic [WORST_W-1:0]    worst_count;
    logic [POS_W-1:0]      worst_at;
    logic [LEN_W-1:0]      bases_in;
    logic [LEN_W-1:0]      read_length;
    logic [WIN_W-1:0]      win_size;
    logic                  hit;

    initial begin
        errors  = 0;
        pending = 0;
    end

    function automatic base_code_t code_of(input logic [BASE_W-1:0] ch);
        case (ch)
            "A", "a":           return CODE_A;
            "C", "c":           return CODE_C;
            "G", "g":           return CODE_G;
            "T", "t", "U", "u": return CODE_T;
            "*", ",", "-":      return CODE_GAP;
            default:            return CODE_NONE;
        endcase
    endfunction

    task automatic score_base(input logic [BASE_W-1:0] rb, input logic [BASE_W-1:0] cb,
                              input logic first, input logic [LEN_W-1:0] len);
        logic [WIN_W-1:0] w;
        logic [31:0]      thresh;
        logic [31:0]      n;
        logic             miss;
        base_code_t       rc;
        base_code_t       cc;
        read_score_t      r;
        if (first) begin
            w = win_setting;
            if (w == 0) begin
                w = WIN_W'(1);
            end
            if (w > WINDOW_MAX) begin
                w = WIN_W'(WINDOW_MAX);
            end
            if (len < MIN_READ_LEN) begin
                w = '0;
            end else if (32'(len) - 2 < 32'(w)) begin
                w = WIN_W'(len - 2);
            end
            thresh      = (32'(frac_setting) * 32'(w) + 32'd32768) >> 16;
            read_length = len;
            bases_in    = '0;
            win_count   = '0;
            win_size    = w;
            worst_count = WORST_W'(thresh);
            worst_at    = '0;
            hit         = 1'b0;
            miss_hist   = '0;
        end
        if (bases_in >= read_length) begin
            return;
        end
        rc = code_of(rb);
        cc = code_of(cb);
        if (ignore_setting) begin
            miss = (rc != CODE_NONE) && (rc != cc);
        end else begin
            miss = (rc != cc);
        end
        n = 32'(bases_in);
        if (win_size > 0) begin
            if (n >= 32'(win_size)) begin
                win_count = win_count - WIN_W'(miss_hist[(n - 32'(win_size)) % WINDOW_MAX]);
            end
            miss_hist[n % WINDOW_MAX] = miss;
            win_count = win_count + WIN_W'(miss);
        end
        n = n + 1;
        bases_in = LEN_W'(n);
        if (win_size > 0 && n >= 32'(win_size) && 32'(win_count) >= 32'(worst_count)) begin
            worst_count = WORST_W'(win_count);
            worst_at    = POS_W'(n);
            hit         = 1'b1;
        end
        if (n != 32'(read_length)) begin
            return;
        end
        if (hit && win_size > 0) begin
            r.score       = SCORE_W'((32'(worst_count) * 32'd10000) / 32'(win_size));
            r.flagged     = 1'b1;
            r.worst_count = worst_count;
            r.worst_end   = worst_at;
        end else begin
            r = '0;
        end
        score_queue.push_back(r);
    endtask

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        read_score_t want;
        if (!aresetn) begin
            win_setting    = WINDOW_LEN_RESET;
            frac_setting   = MAX_FRAC_RESET;
            ignore_setting = 1'b0;
            miss_hist      = '0;
            win_count      = '0;
            worst_count    = '0;
            worst_at       = '0;
            bases_in       = '0;
            read_length    = '0;
            win_size       = '0;
            hit            = 1'b0;
            score_queue.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_WINDOW_LEN:     win_setting = cfg_data[WLEN_W-1:0];
                    CFG_MAX_FRAC:       frac_setting = cfg_data[FRAC_W-1:0];
                    CFG_IGNORE_UNKNOWN: ignore_setting = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                score_base(s_tdata[7:0], s_tdata[15:8], s_tuser, s_tdata[31:16]);
            end
            if (m_tvalid && m_tready) begin
                if (score_queue.size() == 0) begin
                    $error("result with no read awaiting one: score %0d, worst_end %0d",
                           m_tdata[SCORE_W-1:0], m_tdata[PAD_LO-1:END_LO]);
                    errors++;
                end else begin
                    want = score_queue.pop_front();
                    compare_field("score", 32'(want.score), 32'(m_tdata[SCORE_W-1:0]));
                    compare_field("flagged", 32'(want.flagged), 32'(m_tuser));
                    compare_field("worst_count", 32'(want.worst_count),
                                  32'(m_tdata[END_LO-1:WORST_LO]));
                    compare_field("worst_end", 32'(want.worst_end),
                                  32'(m_tdata[PAD_LO-1:END_LO]));
                    compare_field("tdata padding", 32'd0, 32'(m_tdata[M_TDATA_W-1:PAD_LO]));
                end
            end
        end
        pending = score_queue.size();
    end

endmodule

@@ test/windowed_base_mismatch_scorer_tb.sv @@
`timescale 1ns / 100ps

module windowed_base_mismatch_scorer_tb;
    import wbms_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 110;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int   errors;
    int   pending;
    int   cycles = 0;
    logic calm   = 1'b0;

    logic [7:0] alphabet [0:12] = '{"A", "C", "G", "T", "U", "a", "c", "g", "t", "u",
                                    "*", ",", "-"};

    windowed_base_mismatch_scorer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    windowed_base_mismatch_scorer_checker u_score_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 11);
    end

    task automatic send_item(input logic [7:0] rb, input logic [7:0] cb, input logic first,
                             input logic [15:0] len);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 11) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {len, cb, rb};
        s_tuser  <= first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Sends the first count items of a read of the given length; pct is the
    // chance in percent of a deliberate mismatch, 100 forcing every base to differ.
    task automatic send_read(input logic [15:0] len, input int pct, input int count);
        logic [7:0] rb;
        logic [7:0] cb;
        for (int i = 0; i < count; i++) begin
            if (pct >= 100) begin
                rb = "A";
                cb = "-";
            end else begin
                cb = ($urandom_range(9) == 0) ? 8'($urandom) : alphabet[$urandom_range(12)];
                if ($urandom_range(99) < pct) begin
                    rb = ($urandom_range(4) == 0) ? 8'($urandom) : alphabet[$urandom_range(12)];
                end else if (cb[6] && $urandom_range(1)) begin
                    rb = cb ^ 8'h20;
                end else begin
                    rb = cb;
                end
            end
            send_item(rb, cb, i == 0, (i == 0) ? len : 16'($urandom));
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [8:0] win, input logic [15:0] frac, input logic ign);
        wait_idle();
        write_reg(CFG_WINDOW_LEN, {7'($urandom), win});
        write_reg(CFG_MAX_FRAC, frac);
        write_reg(CFG_IGNORE_UNKNOWN, {15'($urandom), ign});
        if ($urandom_range(1)) begin
            write_reg(CFG_UNUSED, 16'($urandom));
        end
    endtask

    task automatic run_reads(input int budget);
        int sent;
        int pick;
        int pct;
        int len;
        int count;
        sent = 0;
        while (sent < budget) begin
            pick  = $urandom_range(99);
            pct   = $urandom_range(100);
            if (pick < 60) begin
                len   = $urandom_range(40, 3);
                count = len;
            end else if (pick < 72) begin
                len   = $urandom_range(130, 41);
                count = len;
            end else if (pick < 76) begin
                len   = $urandom_range(300, 250);
                count = len;
            end else if (pick < 84) begin
                len   = $urandom_range(2, 0);
                count = (len == 0) ? 1 : len;
            end else if (pick < 92) begin
                len   = $urandom_range(60, 4);
                count = $urandom_range(len - 1, 1);
            end else if (pick < 96) begin
                len   = 0;
                count = 0;
                send_item(8'($urandom), 8'($urandom), 1'b0, 16'($urandom));
            end else begin
                len   = $urandom_range(65535);
                count = $urandom_range(5, 1);
            end
            if (count > 0) begin
                send_read(16'(len), pct, count);
            end
            sent += count;
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_item(8'h00, 8'hFF, 1'b0, 16'h0000);
        send_read(16'd1, 50, 1);
        send_read(16'd2, 50, 2);
        send_read(16'd0, 50, 2);
        send_read(16'd3, 100, 3);
        send_read(16'hFFFF, 50, 1);
        for (int i = 0; i < 13; i++) begin
            send_item(alphabet[i], alphabet[(i * 5) % 13], i == 0, (i == 0) ? 16'd13 : 16'hFFFF);
        end
        send_item(8'hFF, 8'h00, 1'b0, 16'hFFFF);

        apply_setting(9'd30, 16'd16384, 1'b0);
        run_reads(PHASE_ITEMS);
        apply_setting(9'd0, 16'd0, 1'b1);
        run_reads(PHASE_ITEMS);
        apply_setting(9'd256, 16'hFFFF, 1'b0);
        send_read(16'd300, 100, 300);
        run_reads(PHASE_ITEMS);
        apply_setting(9'h1FF, 16'h8000, 1'b1);
        run_reads(PHASE_ITEMS);
        apply_setting(9'd1, 16'hFFFF, 1'b0);
        calm = 1'b1;
        run_reads(PHASE_ITEMS);
        apply_setting(9'($urandom_range(64, 2)), 16'($urandom), 1'($urandom));
        calm = 1'b0;
        for (int p = 0; p < 4; p++) begin
            run_reads(PHASE_ITEMS);
            apply_setting(9'($urandom_range(($urandom_range(3) == 0) ? 511 : 64)),
                          16'($urandom), 1'($urandom));
        end
        run_reads(PHASE_ITEMS);
        wait_idle();

        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
